@@ rtl/assert_macros.svh @@
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ZIP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ZIP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/zip_pkg.sv @@
`default_nettype none

package zip_pkg;

  // fixed point and sizes
  localparam int FRAC_BITS = 12;
  localparam int DEF_SIGMOID_ENTRIES = 256;
  localparam int ACC_W = 40;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // one input term
  typedef struct packed {
    logic signed [15:0] design_lm;
    logic signed [15:0] coef_lm;
    logic signed [15:0] design_glm;
    logic signed [15:0] coef_glm;
    logic signed [15:0] effect_lm;
    logic signed [15:0] effect_glm;
    logic               last_term;
  } item_t;

  // one prediction
  typedef struct packed {
    logic signed [31:0] prediction;
    logic               saturated;
  } result_t;

  // finished unit handed from front to back
  typedef struct packed {
    logic signed [ACC_W-1:0] sum_linear;
    logic signed [ACC_W-1:0] sum_logistic;
    logic signed [15:0]      effect_lm;
    logic signed [15:0]      effect_glm;
  } unit_t;

  // saturating add at accumulator width
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  // e^-a in q0.31, a in q.31, evaluated at elaboration only
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] aq);
    logic [63:0] y;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    y  = aq >> 8;
    t2 = (y * y) >> 31;
    t3 = (t2 * y) >> 31;
    t4 = (t3 * y) >> 31;
    e  = (64'd1 << 31) - y + t2 / 64'd2 - t3 / 64'd6 + t4 / 64'd24;
    for (int k = 0; k < 8; k++) begin
      e = (e * e) >> 31;
    end
    return e;
  endfunction

  // sigmoid sample in q0.16 at x given in q.31, evaluated at elaboration only
  function automatic logic [15:0] sig_sample(input logic signed [63:0] xq);
    logic [63:0] aq;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    aq  = (xq < 0) ? 64'(-xq) : 64'(xq);
    den = (64'd1 << 31) + exp_neg_q31(aq);
    num = (64'd1 << 47) + (den >> 1);
    rem = '0;
    quo = '0;
    // restoring division, one quotient bit per step
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    if (xq < 0) begin
      quo = 64'd65536 - quo;
    end
    if (quo > 64'd65535) begin
      quo = 64'd65535;
    end
    return quo[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/zero_inflated_predictor.sv @@
// channel   direction  handshake            payload
// item      in         push / full          zip_pkg::item_t
// result    out        pop / empty          zip_pkg::result_t
//
// one term accepted per cycle while full is low; the front end multiplies, then accumulates
// a last term hands its unit through a two-entry queue to the back end
// back end works on one unit at a time, in steps: capture, effects, index and table read, multiply, clamp
// a unit passes the product register, the queue and the back-end steps before its result is ready
// full rises only while a last term waits on a full queue (short units or held results)
// synchronous reset clears accumulators, queue, sequencer and output; the table is constant

`default_nettype none
`include "assert_macros.svh"

module zero_inflated_predictor #(
  parameter int SIGMOID_ENTRIES = zip_pkg::DEF_SIGMOID_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire zip_pkg::item_t   item,
  output logic                  empty,
  input  wire logic             pop,
  output zip_pkg::result_t      result
);
  import zip_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  unit_t q_in;
  unit_t q_out;

  // accept and accumulate terms
  zip_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_push  (q_push),
    .q_entry (q_in),
    .q_full  (q_full)
  );

  // finished units waiting for the back end
  zip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .entry_out (q_out),
    .valid     (q_valid)
  );

  // sigmoid, product and output register
  zip_back #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_out),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // cross-module checks
  `ZIP_ASSERT_IMP(a_no_push_when_full, q_push, !q_full, "unit pushed into full queue")
  `ZIP_ASSERT_IMP(a_pop_needs_valid, q_pop, q_valid, "back end popped an empty queue")
  `ZIP_ASSERT_IMP(a_stall_from_queue, full, q_full, "front stalled without a full queue")

endmodule

`default_nettype wire

@@ rtl/zip_front.sv @@
`default_nettype none

module zip_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire zip_pkg::item_t item,
  output logic              q_push,
  output zip_pkg::unit_t    q_entry,
  input  wire logic         q_full
);
  import zip_pkg::*;

  logic                    prod_valid;
  logic signed [31:0]      prod_lm;
  logic signed [31:0]      prod_glm;
  logic                    prod_last;
  logic signed [15:0]      prod_eff_lm;
  logic signed [15:0]      prod_eff_glm;
  logic signed [ACC_W-1:0] sum_linear;
  logic signed [ACC_W-1:0] sum_logistic;
  logic signed [ACC_W-1:0] sum_linear_next;
  logic signed [ACC_W-1:0] sum_logistic_next;
  logic                    advance;
  logic                    accept;

  // a last term waits here while the unit queue is full
  assign full    = prod_valid && prod_last && q_full;
  assign accept  = push && !full;
  assign advance = prod_valid && !full;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (accept) begin
      prod_valid <= 1'b1;
    end else if (advance) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_lm      <= item.design_lm * item.coef_lm;
      prod_glm     <= item.design_glm * item.coef_glm;
      prod_last    <= item.last_term;
      prod_eff_lm  <= item.effect_lm;
      prod_eff_glm <= item.effect_glm;
    end
  end

  // accumulate with saturation
  assign sum_linear_next   = sat_add(sum_linear, ACC_W'(prod_lm));
  assign sum_logistic_next = sat_add(sum_logistic, ACC_W'(prod_glm));

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_linear   <= '0;
      sum_logistic <= '0;
    end else if (advance) begin
      if (prod_last) begin
        sum_linear   <= '0;
        sum_logistic <= '0;
      end else begin
        sum_linear   <= sum_linear_next;
        sum_logistic <= sum_logistic_next;
      end
    end
  end

  // hand the finished unit to the back end
  assign q_push               = advance && prod_last;
  assign q_entry.sum_linear   = sum_linear_next;
  assign q_entry.sum_logistic = sum_logistic_next;
  assign q_entry.effect_lm    = prod_eff_lm;
  assign q_entry.effect_glm   = prod_eff_glm;

endmodule

`default_nettype wire

@@ rtl/zip_queue.sv @@
`default_nettype none

module zip_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire zip_pkg::unit_t entry_in,
  output logic                full,
  input  wire logic           pop,
  output zip_pkg::unit_t      entry_out,
  output logic                valid
);
  import zip_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  unit_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign valid     = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;
  assign entry_out = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/zip_sigmoid_rom.sv @@
`default_nettype none

module zip_sigmoid_rom #(
  parameter int SIGMOID_ENTRIES = zip_pkg::DEF_SIGMOID_ENTRIES
) (
  input  wire logic                               clk,
  input  wire logic [$clog2(SIGMOID_ENTRIES)-1:0] addr,
  output logic [15:0]                             data
);
  import zip_pkg::*;

  logic [15:0] samples [SIGMOID_ENTRIES];

  // each entry samples the middle of its bin over [-8,8)
  for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_sample
    localparam logic signed [63:0] XQ =
      (64'sd2 * g + 64'sd1) * (64'sd1 <<< 34) / SIGMOID_ENTRIES - (64'sd1 <<< 34);
    assign samples[g] = sig_sample(XQ);
  end

  // registered read
  always_ff @(posedge clk) begin
    data <= samples[addr];
  end

endmodule

`default_nettype wire

@@ rtl/zip_back.sv @@
`default_nettype none

module zip_back #(
  parameter int SIGMOID_ENTRIES = zip_pkg::DEF_SIGMOID_ENTRIES
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire zip_pkg::unit_t q_entry,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output zip_pkg::result_t    result
);
  import zip_pkg::*;

  localparam int IDX_W     = $clog2(SIGMOID_ENTRIES);
  localparam int SCALE_W   = ACC_W + IDX_W + 1;
  localparam int IDX_SHIFT = 4 + 2 * FRAC_BITS;
  localparam int PROD_W    = ACC_W + 17;
  localparam int OUT_SHIFT = FRAC_BITS + 16;

  localparam logic signed [ACC_W-1:0]  SIG_HALF = ACC_W'(64'sd8 <<< (2 * FRAC_BITS));
  localparam logic [IDX_W-1:0]         IDX_LAST = IDX_W'(SIGMOID_ENTRIES - 1);
  localparam logic signed [PROD_W-1:0] PRED_MAX = PROD_W'(32'sh7fff_ffff);
  localparam logic signed [PROD_W-1:0] PRED_MIN = PROD_W'(32'sh8000_0000);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADD   = 5'b00010,
    ST_INDEX = 5'b00100,
    ST_MULT  = 5'b01000,
    ST_FINAL = 5'b10000
  } state_t;

  state_t                   state;
  state_t                   state_next;
  unit_t                    unit_q;
  logic signed [ACC_W-1:0]  lin;
  logic signed [ACC_W-1:0]  logi;
  logic [ACC_W-1:0]         offset;
  logic [SCALE_W-1:0]       scaled;
  logic [IDX_W-1:0]         idx;
  logic [15:0]              prob;
  logic signed [40:0]       part_hi;
  logic [31:0]              part_lo;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;
  result_t                  res_next;
  logic                     out_valid;
  logic                     out_write;

  // sequencer
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign out_write = (state == ST_FINAL) && (!out_valid || pop);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) state_next = ST_ADD;
      ST_ADD:   state_next = ST_INDEX;
      ST_INDEX: state_next = ST_MULT;
      ST_MULT:  state_next = ST_FINAL;
      ST_FINAL: if (out_write) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture unit and add the random effects
  always_ff @(posedge clk) begin
    if (q_pop) begin
      unit_q <= q_entry;
    end
    if (state == ST_ADD) begin
      lin  <= sat_add(unit_q.sum_linear, ACC_W'(unit_q.effect_lm) <<< FRAC_BITS);
      logi <= sat_add(unit_q.sum_logistic, ACC_W'(unit_q.effect_glm) <<< FRAC_BITS);
    end
  end

  // table index from the logistic sum, clamped outside [-8,8)
  assign offset = $unsigned(logi + SIG_HALF);
  assign scaled = SCALE_W'(offset) * SCALE_W'(SIGMOID_ENTRIES);

  always_comb begin
    if (logi < -SIG_HALF) begin
      idx = '0;
    end else if (logi >= SIG_HALF) begin
      idx = IDX_LAST;
    end else begin
      idx = scaled[IDX_SHIFT +: IDX_W];
    end
  end

  zip_sigmoid_rom #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .addr (idx),
    .data (prob)
  );

  // split product: upper 24 bits and lower 16 bits of the linear sum
  always_ff @(posedge clk) begin
    if (state == ST_MULT) begin
      part_hi <= $signed(lin[ACC_W-1:16]) * $signed({1'b0, prob});
      part_lo <= lin[15:0] * prob;
    end
  end

  // recombine, floor shift and clamp to 32 bits
  assign prod    = $signed({part_hi, 16'h0000}) + $signed({25'h0, part_lo});
  assign shifted = prod >>> OUT_SHIFT;

  always_comb begin
    if (shifted > PRED_MAX) begin
      res_next.prediction = PRED_MAX[31:0];
      res_next.saturated  = 1'b1;
    end else if (shifted < PRED_MIN) begin
      res_next.prediction = PRED_MIN[31:0];
      res_next.saturated  = 1'b1;
    end else begin
      res_next.prediction = shifted[31:0];
      res_next.saturated  = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_write) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_write) begin
      result <= res_next;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire
